// ----- hw/rtl/lpcl_pkg.sv -----
`default_nettype none

package lpcl_pkg;

    // pixel store geometry
    localparam int MAX_PIXELS = 1048576;
    localparam int PIX_AW     = $clog2(MAX_PIXELS);
    localparam int ENTRY_W    = 20;
    localparam int RGB_W      = 24;

    // projection matrix, 3 rows of 4 coefficients
    localparam int COEF_N  = 12;
    localparam int COEF_AW = $clog2(COEF_N);
    localparam int COEF_W  = 32;

    // configuration registers
    localparam int DIM_W  = 11;
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COLS = 2'd1;

    // item modes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_LOAD_COEF  = 2'd0;
    localparam mode_t MODE_LOAD_PIXEL = 2'd1;
    localparam mode_t MODE_PROJECT    = 2'd2;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_FOUND   = 2'd0;
    localparam status_t STATUS_OUTSIDE = 2'd1;
    localparam status_t STATUS_ZERO_D  = 2'd2;

    // datapath widths
    localparam int ACC_W      = 50;
    localparam int MAG_W      = ACC_W;
    localparam int Q_W        = 16;
    localparam int DIV_STAGES = Q_W;
    localparam int DIV_W      = MAG_W + DIV_STAGES - 1;
    localparam int VPROD_W    = Q_W + DIM_W + 1;
    localparam int IDX_W      = VPROD_W + 1;

    // item fields that ride along the whole pipeline
    typedef struct packed {
        mode_t              mode;
        logic [ENTRY_W-1:0] entry_index;
        logic [RGB_W-1:0]   rgb;
    } item_ctl_t;

    // one divider stage, both quotients side by side
    typedef struct packed {
        item_ctl_t          ctl;
        logic [MAG_W-1:0]   rem_u;
        logic [MAG_W-1:0]   rem_v;
        logic [MAG_W-1:0]   den;
        logic [Q_W-1:0]     q_u;
        logic [Q_W-1:0]     q_v;
        logic               neg_u;
        logic               neg_v;
        logic               zero;
    } div_lane_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpcl_pt_if.sv -----
`default_nettype none

interface lpcl_pt_if;
    logic                          valid;
    logic                          ready;
    lpcl_pkg::mode_t               mode;
    logic [lpcl_pkg::ENTRY_W-1:0]  entry_index;
    logic signed [31:0]            coefficient;
    logic [7:0]                    red_in;
    logic [7:0]                    green_in;
    logic [7:0]                    blue_in;
    logic signed [31:0]            point_x;
    logic signed [31:0]            point_y;
    logic signed [31:0]            point_z;

    modport source (output valid, mode, entry_index, coefficient, red_in, green_in,
                    blue_in, point_x, point_y, point_z, input ready);
    modport sink (input valid, mode, entry_index, coefficient, red_in, green_in,
                  blue_in, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lpcl_res_if.sv -----
`default_nettype none

interface lpcl_res_if;
    logic                 valid;
    logic                 ready;
    lpcl_pkg::status_t    status;
    logic [7:0]           red_out;
    logic [7:0]           green_out;
    logic [7:0]           blue_out;
    logic signed [15:0]   pixel_u;
    logic signed [15:0]   pixel_v;

    modport source (output valid, status, red_out, green_out, blue_out, pixel_u, pixel_v,
                    input ready);
    modport sink (input valid, status, red_out, green_out, blue_out, pixel_u, pixel_v,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lpcl_cfg_if.sv -----
`default_nettype none

interface lpcl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lpcl_pkg::CFG_AW-1:0]   index;
    logic [lpcl_pkg::DIM_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lidar_point_colour_lookup_core.sv -----
// Lidar point colour lookup.
// Channel pts carries load and project beats. A coefficient load writes one entry of
// the 3x4 projection matrix at once; a pixel load travels down the pipeline and
// writes the pixel store at the lookup stage, so loads and lookups stay in order.
// A project beat gives one beat on res: status, colour and the pixel column/row.
// Load beats and the unused mode give nothing on res.
// Channel cfg writes image_rows (index 0) and image_cols (index 1); it is always ready.
// The user must write it only while no item is in flight; the block does not enforce this.
// A project beat passes through 22 register stages on its way to res: multiply,
// accumulate, sign split, 16 restoring divider steps, saturate, index multiply,
// pixel store read. Throughput: one beat per cycle on pts while res does not stall;
// every stage holds one item.
// The whole pipeline advances when the output register is empty or res.ready is
// high; while res stalls nothing moves and pts.ready is low.
// Reset clears the matrix to zero, sets rows and cols to 1 and empties the
// pipeline. The pixel store is not cleared: an unloaded pixel reads undefined.
`default_nettype none

module lidar_point_colour_lookup_core (
    input  wire        clk,
    input  wire        rst_n,
    lpcl_pt_if.sink    pts,
    lpcl_cfg_if.sink   cfg,
    lpcl_res_if.source res
);

    localparam int NS = lpcl_pkg::DIV_STAGES;

    logic adv;
    logic in_acc;

    // configuration registers
    logic [lpcl_pkg::DIM_W-1:0] rows_reg;
    logic [lpcl_pkg::DIM_W-1:0] cols_reg;

    logic signed [lpcl_pkg::COEF_W-1:0] matrix_reg [lpcl_pkg::COEF_N];
    logic signed [31:0] coord [3];
    lpcl_pkg::item_ctl_t in_ctl;

    // stage 1: products
    logic                 s1_vld_reg;
    lpcl_pkg::item_ctl_t  s1_ctl_reg;
    logic signed [63:0]   s1_prod_reg [3][3];
    logic signed [31:0]   s1_m3_reg [3];

    // stage 2: row sums
    logic                 s2_vld_reg;
    lpcl_pkg::item_ctl_t  s2_ctl_reg;
    logic signed [lpcl_pkg::ACC_W-1:0] s2_acc_reg [3];

    // divider pipeline, entry 0 is the sign split stage
    logic                 div_vld_reg [NS+1];
    lpcl_pkg::div_lane_t  div_reg [NS+1];
    lpcl_pkg::div_lane_t  div_first;

    // stage 4: saturated quotients
    logic                 s4_vld_reg;
    lpcl_pkg::item_ctl_t  s4_ctl_reg;
    logic signed [15:0]   s4_u_reg;
    logic signed [15:0]   s4_v_reg;
    logic                 s4_zero_reg;

    // stage 5: row offset
    logic                 s5_vld_reg;
    lpcl_pkg::item_ctl_t  s5_ctl_reg;
    logic signed [15:0]   s5_u_reg;
    logic signed [15:0]   s5_v_reg;
    logic                 s5_zero_reg;
    logic signed [lpcl_pkg::VPROD_W-1:0] s5_vprod_reg;

    // stage 6: output register and pixel store
    logic                 s6_vld_reg;
    lpcl_pkg::status_t    s6_status_reg;
    logic signed [15:0]   s6_u_reg;
    logic signed [15:0]   s6_v_reg;
    logic [lpcl_pkg::RGB_W-1:0] s6_rgb_reg;

    logic [lpcl_pkg::RGB_W-1:0] pix_mem [lpcl_pkg::MAX_PIXELS];

    logic signed [lpcl_pkg::IDX_W-1:0] lin_idx;
    logic [2*lpcl_pkg::DIM_W-1:0]      limit;
    logic                              in_img;
    lpcl_pkg::status_t                 status_next;
    logic                              pix_wr;

    function automatic logic signed [lpcl_pkg::ACC_W-1:0] floor_q16(
        input logic signed [63:0] p
    );
        floor_q16 = {{(lpcl_pkg::ACC_W-48){p[63]}}, p[63:16]};
    endfunction

    function automatic logic [lpcl_pkg::MAG_W-1:0] mag(
        input logic signed [lpcl_pkg::ACC_W-1:0] a
    );
        mag = a[lpcl_pkg::ACC_W-1] ? lpcl_pkg::MAG_W'(-a) : lpcl_pkg::MAG_W'(a);
    endfunction

    function automatic logic signed [15:0] sat_q(
        input logic [lpcl_pkg::Q_W-1:0] q,
        input logic neg
    );
        logic signed [15:0] m;
        m = {1'b0, q[lpcl_pkg::Q_W-2:0]};
        if (q[lpcl_pkg::Q_W-1])
            sat_q = neg ? 16'sh8000 : 16'sh7fff;
        else
            sat_q = neg ? -m : m;
    endfunction

    // global advance: output register empty or being taken
    assign adv       = !s6_vld_reg || res.ready;
    assign pts.ready = adv;
    assign in_acc    = pts.valid && adv;
    assign cfg.ready = 1'b1;

    assign coord[0] = pts.point_x;
    assign coord[1] = pts.point_y;
    assign coord[2] = pts.point_z;

    always_comb
    begin
        in_ctl.mode        = pts.mode;
        in_ctl.entry_index = pts.entry_index;
        in_ctl.rgb         = {pts.red_in, pts.green_in, pts.blue_in};
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= lpcl_pkg::DIM_W'(1);
            cols_reg <= lpcl_pkg::DIM_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lpcl_pkg::CFG_ROWS: rows_reg <= cfg.data;
                lpcl_pkg::CFG_COLS: cols_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // coefficient loads take effect at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lpcl_pkg::COEF_N; i++)
                matrix_reg[i] <= '0;
        end
        else if (in_acc && pts.mode == lpcl_pkg::MODE_LOAD_COEF &&
                 pts.entry_index < lpcl_pkg::ENTRY_W'(lpcl_pkg::COEF_N))
        begin
            matrix_reg[pts.entry_index[lpcl_pkg::COEF_AW-1:0]] <= pts.coefficient;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
                div_vld_reg[k] <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg     <= pts.valid;
            s2_vld_reg     <= s1_vld_reg;
            div_vld_reg[0] <= s2_vld_reg;
            for (int k = 0; k < NS; k++)
                div_vld_reg[k+1] <= div_vld_reg[k];
            s4_vld_reg <= div_vld_reg[NS];
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg && s5_ctl_reg.mode == lpcl_pkg::MODE_PROJECT;
        end
    end

    // stage 1: nine coefficient by coordinate products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg <= in_ctl;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    s1_prod_reg[r][c] <= matrix_reg[r*4+c] * coord[c];
                s1_m3_reg[r] <= matrix_reg[r*4+3];
            end
        end
    end

    // stage 2: floor each product to Q16.16 and sum the row
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            for (int r = 0; r < 3; r++)
                s2_acc_reg[r] <= floor_q16(s1_prod_reg[r][0]) +
                                 floor_q16(s1_prod_reg[r][1]) +
                                 floor_q16(s1_prod_reg[r][2]) +
                                 {{(lpcl_pkg::ACC_W-32){s1_m3_reg[r][31]}}, s1_m3_reg[r]};
        end
    end

    // sign split into magnitudes for the divider
    always_comb
    begin
        div_first.ctl   = s2_ctl_reg;
        div_first.rem_u = mag(s2_acc_reg[0]);
        div_first.rem_v = mag(s2_acc_reg[1]);
        div_first.den   = mag(s2_acc_reg[2]);
        div_first.q_u   = '0;
        div_first.q_v   = '0;
        div_first.neg_u = s2_acc_reg[0][lpcl_pkg::ACC_W-1] ^ s2_acc_reg[2][lpcl_pkg::ACC_W-1];
        div_first.neg_v = s2_acc_reg[1][lpcl_pkg::ACC_W-1] ^ s2_acc_reg[2][lpcl_pkg::ACC_W-1];
        div_first.zero  = (s2_acc_reg[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            div_reg[0] <= div_first;
    end

    // restoring divider, one quotient bit per stage, top bit flags saturation
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        localparam int SH = NS - 1 - k;
        logic [lpcl_pkg::DIV_W-1:0] dsh;
        logic [lpcl_pkg::DIV_W-1:0] ru;
        logic [lpcl_pkg::DIV_W-1:0] rv;
        lpcl_pkg::div_lane_t        nxt;

        always_comb
        begin
            dsh = lpcl_pkg::DIV_W'(div_reg[k].den) << SH;
            ru  = lpcl_pkg::DIV_W'(div_reg[k].rem_u);
            rv  = lpcl_pkg::DIV_W'(div_reg[k].rem_v);
            nxt = div_reg[k];
            if (ru >= dsh)
            begin
                nxt.rem_u     = lpcl_pkg::MAG_W'(ru - dsh);
                nxt.q_u[SH]   = 1'b1;
            end
            if (rv >= dsh)
            begin
                nxt.rem_v     = lpcl_pkg::MAG_W'(rv - dsh);
                nxt.q_v[SH]   = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                div_reg[k+1] <= nxt;
        end
    end

    // stage 4: sign and saturate the quotients
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ctl_reg  <= div_reg[NS].ctl;
            s4_zero_reg <= div_reg[NS].zero;
            s4_u_reg    <= div_reg[NS].zero ? 16'sd0 : sat_q(div_reg[NS].q_u, div_reg[NS].neg_u);
            s4_v_reg    <= div_reg[NS].zero ? 16'sd0 : sat_q(div_reg[NS].q_v, div_reg[NS].neg_v);
        end
    end

    // stage 5: row offset v * cols
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_ctl_reg   <= s4_ctl_reg;
            s5_u_reg     <= s4_u_reg;
            s5_v_reg     <= s4_v_reg;
            s5_zero_reg  <= s4_zero_reg;
            s5_vprod_reg <= s4_v_reg * $signed({1'b0, cols_reg});
        end
    end

    // linear index and bounds check
    always_comb
    begin
        limit   = rows_reg * cols_reg;
        lin_idx = lpcl_pkg::IDX_W'(s5_vprod_reg) + lpcl_pkg::IDX_W'(s5_u_reg);
        in_img  = !lin_idx[lpcl_pkg::IDX_W-1] &&
                  ($unsigned(lin_idx) < lpcl_pkg::IDX_W'(limit)) &&
                  ($unsigned(lin_idx) < lpcl_pkg::IDX_W'(lpcl_pkg::MAX_PIXELS));
        if (s5_zero_reg)
            status_next = lpcl_pkg::STATUS_ZERO_D;
        else if (in_img)
            status_next = lpcl_pkg::STATUS_FOUND;
        else
            status_next = lpcl_pkg::STATUS_OUTSIDE;
        pix_wr = s5_vld_reg && s5_ctl_reg.mode == lpcl_pkg::MODE_LOAD_PIXEL &&
                 (32'(s5_ctl_reg.entry_index) < 32'(lpcl_pkg::MAX_PIXELS));
    end

    // pixel store: loads and lookups in pipeline order
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pix_wr)
                pix_mem[lpcl_pkg::PIX_AW'(s5_ctl_reg.entry_index)] <= s5_ctl_reg.rgb;
            s6_rgb_reg <= pix_mem[lin_idx[lpcl_pkg::PIX_AW-1:0]];
        end
    end

    // stage 6: result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_status_reg <= status_next;
            s6_u_reg      <= s5_u_reg;
            s6_v_reg      <= s5_v_reg;
        end
    end

    // result beat, colour only when found
    assign res.valid     = s6_vld_reg;
    assign res.status    = s6_status_reg;
    assign res.pixel_u   = s6_u_reg;
    assign res.pixel_v   = s6_v_reg;
    assign res.red_out   = (s6_status_reg == lpcl_pkg::STATUS_FOUND) ? s6_rgb_reg[23:16] : 8'd0;
    assign res.green_out = (s6_status_reg == lpcl_pkg::STATUS_FOUND) ? s6_rgb_reg[15:8] : 8'd0;
    assign res.blue_out  = (s6_status_reg == lpcl_pkg::STATUS_FOUND) ? s6_rgb_reg[7:0] : 8'd0;

endmodule

`default_nettype wire

// ----- tb/tb_lidar_point_colour_lookup_core.sv -----
`timescale 1ns / 100ps

module tb_lidar_point_colour_lookup_core;

    localparam int CLK_HALF  = 10;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 40;
    localparam int N_RANDOM  = 480;

    // one beat on the point channel
    typedef struct {
        lpcl_pkg::mode_t              mode;
        logic [lpcl_pkg::ENTRY_W-1:0] idx;
        logic signed [31:0]           coef;
        logic [7:0]                   r;
        logic [7:0]                   g;
        logic [7:0]                   b;
        logic signed [31:0]           x;
        logic signed [31:0]           y;
        logic signed [31:0]           z;
    } pt_beat_t;

    // one colour lookup result
    typedef struct {
        lpcl_pkg::status_t  st;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic signed [15:0] u;
        logic signed [15:0] v;
    } colour_res_t;

    // directed table row
    typedef struct {
        pt_beat_t    beat;
        bit          typed;
        colour_res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    lpcl_pt_if  pts_if();
    lpcl_cfg_if cfg_if();
    lpcl_res_if res_if();

    lidar_point_colour_lookup_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pts   (pts_if.sink),
        .cfg   (cfg_if.sink),
        .res   (res_if.source)
    );

    // shadow copy of the block state
    logic signed [31:0] coef_mtx [lpcl_pkg::COEF_N];
    logic [23:0]        pixel_mem [int];
    int                 rows_q;
    int                 cols_q;

    colour_res_t colour_q [$];
    colour_res_t got_w;
    int          fails;
    int          wdog_cnt;
    bit          calm;
    dir_row_t    dir_tab [$];

    initial begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // projection, divide and lookup as the block computes them
    function automatic colour_res_t project_point(pt_beat_t p, output longint lin);
        colour_res_t e;
        longint      acc [3];
        longint      u;
        longint      v;
        longint      lim;
        e = '{lpcl_pkg::STATUS_ZERO_D, 8'd0, 8'd0, 8'd0, 16'sd0, 16'sd0};
        lin = -1;
        for (int rr = 0; rr < 3; rr++)
        begin
            acc[rr] = ((longint'(coef_mtx[rr*4]) * longint'(p.x)) >>> 16)
                    + ((longint'(coef_mtx[rr*4+1]) * longint'(p.y)) >>> 16)
                    + ((longint'(coef_mtx[rr*4+2]) * longint'(p.z)) >>> 16)
                    + longint'(coef_mtx[rr*4+3]);
        end
        if (acc[2] != 0)
        begin
            u = acc[0] / acc[2];
            v = acc[1] / acc[2];
            if (u > 32767) u = 32767;
            if (u < -32768) u = -32768;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            e.u = u[15:0];
            e.v = v[15:0];
            lin = v * longint'(cols_q) + u;
            lim = longint'(rows_q) * longint'(cols_q);
            if (lin >= 0 && lin < lim && lin < lpcl_pkg::MAX_PIXELS)
            begin
                e.st = lpcl_pkg::STATUS_FOUND;
                if (pixel_mem.exists(int'(lin)))
                    {e.r, e.g, e.b} = pixel_mem[int'(lin)];
            end
            else
                e.st = lpcl_pkg::STATUS_OUTSIDE;
        end
        return e;
    endfunction

    // put one beat on the point channel, with random gaps
    task automatic drive_beat(pt_beat_t p);
        while (!calm && $urandom_range(0, 99) < 28)
        begin
            pts_if.valid <= 1'b0;
            @(posedge clk);
        end
        pts_if.valid       <= 1'b1;
        pts_if.mode        <= p.mode;
        pts_if.entry_index <= p.idx;
        pts_if.coefficient <= p.coef;
        pts_if.red_in      <= p.r;
        pts_if.green_in    <= p.g;
        pts_if.blue_in     <= p.b;
        pts_if.point_x     <= p.x;
        pts_if.point_y     <= p.y;
        pts_if.point_z     <= p.z;
        @(posedge clk);
        while (!pts_if.ready) @(posedge clk);
    endtask

    // update shadow state, queue the expected colour, send the beat
    task automatic issue(pt_beat_t p, bit typed, colour_res_t want);
        colour_res_t e;
        pt_beat_t    fill;
        longint      lin;
        if (p.mode == lpcl_pkg::MODE_LOAD_COEF)
        begin
            if (p.idx < lpcl_pkg::COEF_N) coef_mtx[p.idx] = p.coef;
        end
        else if (p.mode == lpcl_pkg::MODE_LOAD_PIXEL)
        begin
            if (p.idx < lpcl_pkg::MAX_PIXELS) pixel_mem[int'(p.idx)] = {p.r, p.g, p.b};
        end
        else if (p.mode == lpcl_pkg::MODE_PROJECT)
        begin
            e = project_point(p, lin);
            // never look up a pixel that holds nothing yet
            if (e.st == lpcl_pkg::STATUS_FOUND && !pixel_mem.exists(int'(lin)))
            begin
                fill = p;
                fill.mode = lpcl_pkg::MODE_LOAD_PIXEL;
                fill.idx = lin[lpcl_pkg::ENTRY_W-1:0];
                fill.r = 8'($urandom);
                fill.g = 8'($urandom);
                fill.b = 8'($urandom);
                pixel_mem[int'(lin)] = {fill.r, fill.g, fill.b};
                drive_beat(fill);
                e = project_point(p, lin);
            end
            colour_q.insert(colour_q.size(), typed ? want : e);
        end
        drive_beat(p);
    endtask

    // config write while the pipeline is empty
    task automatic write_cfg(logic [lpcl_pkg::CFG_AW-1:0] idx, int val);
        pts_if.valid <= 1'b0;
        while (colour_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val[lpcl_pkg::DIM_W-1:0];
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == lpcl_pkg::CFG_ROWS) rows_q = val & 32'h7FF;
        else cols_q = val & 32'h7FF;
    endtask

    function automatic pt_beat_t mk_beat(lpcl_pkg::mode_t m, int idx, int coef, int rgb,
                                         int x, int y, int z);
        pt_beat_t p;
        p.mode = m;
        p.idx = idx[lpcl_pkg::ENTRY_W-1:0];
        p.coef = coef;
        {p.r, p.g, p.b} = rgb[23:0];
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic void add_row(pt_beat_t p, bit typed, lpcl_pkg::status_t st,
                                    int rgb, int u, int v);
        dir_row_t d;
        d.beat = p;
        d.typed = typed;
        d.want.st = st;
        {d.want.r, d.want.g, d.want.b} = rgb[23:0];
        d.want.u = u[15:0];
        d.want.v = v[15:0];
        dir_tab.insert(dir_tab.size(), d);
    endfunction

    function automatic pt_beat_t coef_beat(int idx, int coef);
        return mk_beat(lpcl_pkg::MODE_LOAD_COEF, idx, coef, 0, 0, 0, 0);
    endfunction

    function automatic pt_beat_t proj_beat(int x, int y, int z);
        return mk_beat(lpcl_pkg::MODE_PROJECT, 0, 0, 0, x, y, z);
    endfunction

    // pinhole matrix scaled to the current image
    task automatic load_camera();
        int fu;
        int fv;
        int cw;
        int rh;
        cw = (cols_q == 0) ? 1 : cols_q;
        rh = (rows_q == 0) ? 1 : rows_q;
        fu = $urandom_range(1, (cw + 1) / 2) * 65536 + $urandom_range(0, 65535);
        fv = $urandom_range(1, (rh + 1) / 2) * 65536 + $urandom_range(0, 65535);
        issue(coef_beat(0, fu), 0, '{default: '0});
        issue(coef_beat(1, 0), 0, '{default: '0});
        issue(coef_beat(2, cw * 32768), 0, '{default: '0});
        issue(coef_beat(3, $urandom_range(0, 3) * 65536), 0, '{default: '0});
        issue(coef_beat(4, 0), 0, '{default: '0});
        issue(coef_beat(5, fv), 0, '{default: '0});
        issue(coef_beat(6, rh * 32768), 0, '{default: '0});
        issue(coef_beat(7, $urandom_range(0, 3) * 65536), 0, '{default: '0});
        issue(coef_beat(8, 0), 0, '{default: '0});
        issue(coef_beat(9, 0), 0, '{default: '0});
        issue(coef_beat(10, 65536), 0, '{default: '0});
        issue(coef_beat(11, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : 0),
              0, '{default: '0});
    endtask

    // one random beat: mostly well-formed projections
    task automatic random_beat();
        pt_beat_t p;
        int       sel;
        int       zz;
        sel = $urandom_range(0, 99);
        p = mk_beat(lpcl_pkg::MODE_PROJECT, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        if (sel < 6)
        begin
            p.mode = lpcl_pkg::MODE_LOAD_COEF;
            if ($urandom_range(0, 3) != 0) p.idx = $urandom_range(0, 15);
        end
        else if (sel < 12)
            p.mode = lpcl_pkg::MODE_LOAD_PIXEL;
        else if (sel < 15)
            p.mode = 2'd3;
        else if (sel < 30)
            p.mode = lpcl_pkg::MODE_PROJECT;
        else
        begin
            zz = $urandom_range(65536, 20 * 65536);
            if ($urandom_range(0, 19) == 0) zz = -zz;
            p.z = zz;
            zz = (zz < 0) ? -zz : zz;
            p.x = int'($urandom_range(0, 2 * zz)) - zz;
            p.y = int'($urandom_range(0, 2 * zz)) - zz;
        end
        issue(p, 0, '{default: '0});
    endtask

    // result side: random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    // compare each result beat with the oldest expected colour
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (colour_q.size() == 0)
            begin
                $error("result beat with no expected colour pending");
                fails++;
            end
            else
            begin
                got_w = colour_q.pop_front();
                if (res_if.status !== got_w.st)
                begin
                    $error("status exp %0d got %0d", got_w.st, res_if.status);
                    fails++;
                end
                if (res_if.red_out !== got_w.r)
                begin
                    $error("red_out exp %0d got %0d", got_w.r, res_if.red_out);
                    fails++;
                end
                if (res_if.green_out !== got_w.g)
                begin
                    $error("green_out exp %0d got %0d", got_w.g, res_if.green_out);
                    fails++;
                end
                if (res_if.blue_out !== got_w.b)
                begin
                    $error("blue_out exp %0d got %0d", got_w.b, res_if.blue_out);
                    fails++;
                end
                if (res_if.pixel_u !== got_w.u)
                begin
                    $error("pixel_u exp %0d got %0d", got_w.u, res_if.pixel_u);
                    fails++;
                end
                if (res_if.pixel_v !== got_w.v)
                begin
                    $error("pixel_v exp %0d got %0d", got_w.v, res_if.pixel_v);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge clk)
    begin
        if (!rst_n)
            wdog_cnt <= 0;
        else if ((pts_if.valid && pts_if.ready) || (res_if.valid && res_if.ready)
                 || (cfg_if.valid && cfg_if.ready))
            wdog_cnt <= 0;
        else if (wdog_cnt >= WDOG_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            wdog_cnt <= wdog_cnt + 1;
    end

    initial
    begin
        int phase_rows [8];
        int phase_cols [8];
        int per_phase;
        fails = 0;
        calm = 1'b0;
        rows_q = 1;
        cols_q = 1;
        foreach (coef_mtx[i]) coef_mtx[i] = '0;
        rst_n = 1'b0;
        pts_if.valid = 1'b0;
        pts_if.mode = lpcl_pkg::MODE_LOAD_COEF;
        pts_if.entry_index = '0;
        pts_if.coefficient = '0;
        pts_if.red_in = '0;
        pts_if.green_in = '0;
        pts_if.blue_in = '0;
        pts_if.point_x = '0;
        pts_if.point_y = '0;
        pts_if.point_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = lpcl_pkg::CFG_ROWS;
        cfg_if.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(proj_beat(0, 0, 0), 1, lpcl_pkg::STATUS_ZERO_D, 0, 0, 0);
        add_row(coef_beat(12, 32'h12345678), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(32'hFFFFF, 32'h7FFFFFFF), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(mk_beat(2'd3, 32'hFFFFF, -1, 32'hFFFFFF, -1, -1, -1), 0,
                lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(mk_beat(lpcl_pkg::MODE_LOAD_PIXEL, 32'hFFFFF, 0, 32'hFFFFFF, 0, 0, 0), 0,
                lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(mk_beat(lpcl_pkg::MODE_LOAD_PIXEL, 0, 0, 32'h123456, 0, 0, 0), 0,
                lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(11, 65536), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(proj_beat(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1,
                lpcl_pkg::STATUS_FOUND, 32'h123456, 0, 0);
        add_row(coef_beat(3, 32'h80000000), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(proj_beat(0, 0, 0), 1, lpcl_pkg::STATUS_OUTSIDE, 0, -32768, 0);
        add_row(coef_beat(3, 32'h7FFFFFFF), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(11, 1), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(proj_beat(0, 0, 0), 1, lpcl_pkg::STATUS_OUTSIDE, 0, 32767, 0);
        add_row(coef_beat(7, -65536), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(proj_beat(32'h80000000, 0, 32'h7FFFFFFF), 0,
                lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(0, 32'h7FFFFFFF), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(5, 32'h80000000), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(10, 32'h7FFFFFFF), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(proj_beat(32'h7FFFFFFF, 32'h80000000, 32'h80000000), 0,
                lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(proj_beat(32'h80000000, 32'h7FFFFFFF, 1), 0,
                lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(10, 0), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(coef_beat(11, 0), 0, lpcl_pkg::STATUS_FOUND, 0, 0, 0);
        add_row(proj_beat(-1, -1, -1), 1, lpcl_pkg::STATUS_ZERO_D, 0, 0, 0);
        foreach (dir_tab[i]) issue(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

        // random phases over several image sizes, extremes included
        phase_rows = '{480, 0, 2047, 1, 1024, 37, 1024, 3};
        phase_cols = '{640, 5, 2047, 1024, 1, 53, 1024, 0};
        per_phase = N_RANDOM / 8;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_cfg(lpcl_pkg::CFG_ROWS, phase_rows[ph]);
            write_cfg(lpcl_pkg::CFG_COLS, phase_cols[ph]);
            calm = (ph == 2);
            load_camera();
            for (int n = 0; n < per_phase; n++)
            begin
                if ($urandom_range(0, 49) == 0) load_camera();
                random_beat();
            end
        end
        calm = 1'b0;
        pts_if.valid <= 1'b0;

        // drain
        while (colour_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
